### rtl/assert_macros.svh
// Assertion macros used by the checker file lbcc_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is low
`define CHK_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off while reset is low
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication, also checked through reset
`define CHK_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/lbcc_pkg.sv
// Shared types, constants and functions for the layered box collision check.
// No dependencies.
package lbcc_pkg;

  localparam int NUM_LAYERS  = 4;
  localparam int TABLE_SLOTS = 8;
  localparam int SLOT_W      = 3;
  localparam int CNT_W       = 4;
  localparam int LYR_W       = 2;
  localparam int ID_W        = 8;
  localparam int CRD_W       = 16;
  localparam int SZ_W        = 15;
  localparam int EDGE_W      = 18;
  localparam int CFG_W       = 6;
  localparam int PAIR_W      = 3;
  localparam int QDEPTH      = 2;

  localparam logic [1:0] REG_PAIR_EN = 2'd0;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TICK   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_RS_RD,
    B_RS_CHK,
    B_SH_RD,
    B_SH_WR,
    B_TK_RD,
    B_TK_CMP,
    B_EMIT,
    B_RESP
  } bstate_t;

  typedef struct packed {
    logic [LYR_W-1:0]        layer;
    logic [ID_W-1:0]         id;
    logic signed [CRD_W-1:0] px;
    logic signed [CRD_W-1:0] py;
    logic [SZ_W-1:0]         w;
    logic [SZ_W-1:0]         h;
  } slot_t;

  typedef struct packed {
    op_t   op;
    slot_t box;
  } cmd_t;

  typedef struct packed {
    logic             hit;
    logic [ID_W-1:0]  fid;
    logic [LYR_W-1:0] fl;
    logic [ID_W-1:0]  sid;
    logic [LYR_W-1:0] sl;
    status_t          status;
    logic             last;
  } res_t;

  function automatic logic pair_on(input logic [LYR_W-1:0] li, input logic [LYR_W-1:0] lj,
                                   input logic [CFG_W-1:0] en);
    int idx;
    idx = (int'(li) * (2 * NUM_LAYERS - int'(li) - 1)) / 2 + int'(lj) - int'(li) - 1;
    if (idx < CFG_W) return en[idx[PAIR_W-1:0]];
    return 1'b1;
  endfunction

  function automatic logic overlap(input slot_t a, input slot_t b);
    logic signed [EDGE_W-1:0] ax, ay, bx, by, aw, ah, bw, bh;
    ax = {a.px[CRD_W-1], a.px, 1'b0};
    ay = {a.py[CRD_W-1], a.py, 1'b0};
    bx = {b.px[CRD_W-1], b.px, 1'b0};
    by = {b.py[CRD_W-1], b.py, 1'b0};
    aw = {3'b000, a.w};
    ah = {3'b000, a.h};
    bw = {3'b000, b.w};
    bh = {3'b000, b.h};
    if (a.w == '0 || a.h == '0 || b.w == '0 || b.h == '0) return 1'b0;
    if ((ax - aw > bx + bw) || (bx - bw > ax + aw)) return 1'b0;
    if ((ay - ah > by + bh) || (by - bh > ay + ah)) return 1'b0;
    return 1'b1;
  endfunction

endpackage

### rtl/layered_box_collision_check.sv
// Top level of the layered box collision check: ports, config register, front and back.
// Depends on lbcc_pkg, lbcc_front, lbcc_back.
//
//   channel  | direction | accepted when
//   in_*     | input     | in_tvalid & in_tready
//   out_*    | output    | out_tvalid & out_tready
//   cfg_*    | config    | cfg_psel & cfg_penable & cfg_pwrite & cfg_pready
//
// Add and unused op: after dequeue, the back end goes from B_IDLE to B_RESP and responds.
// Remove: each slot searched passes B_RS_RD and B_RS_CHK, each slot moved up B_SH_RD and B_SH_WR.
// Tick: each box pair of each enabled layer pair passes B_TK_RD and B_TK_CMP;
// each disabled layer pair passes B_TK_RD once, in the pair sweep through the table memory.
// Reset is synchronous; table contents are not cleared, only the box count.
// A stalled output holds the sweep once a new hit finds a result pending; the two-word queue accepts until full.
module layered_box_collision_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // layer, collider_id, pos_x, pos_y, box_width, box_height
  input  logic [1:0]  in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // first_id, first_layer, second_id, second_layer, status, pad
  output logic [0:0]  out_tuser,  // hit_valid
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lbcc_pkg::*;

  logic [CFG_W-1:0] pair_en_r, pair_en_nxt;
  slot_t            in_box;
  logic             q_valid, q_pop;
  cmd_t             q_cmd;
  res_t             res;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {{(32 - CFG_W){1'b0}}, pair_en_r};

  always_comb begin
    pair_en_nxt = pair_en_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == REG_PAIR_EN))
      pair_en_nxt = cfg_pwdata[CFG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pair_en_r <= {CFG_W{1'b1}};
    else        pair_en_r <= pair_en_nxt;
  end

  assign in_box.layer = in_tdata[1:0];
  assign in_box.id    = in_tdata[9:2];
  assign in_box.px    = in_tdata[25:10];
  assign in_box.py    = in_tdata[41:26];
  assign in_box.w     = in_tdata[56:42];
  assign in_box.h     = in_tdata[71:57];

  lbcc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_op    (in_tuser),
    .in_box   (in_box),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  lbcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop),
    .pair_en   (pair_en_r),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {2'b00, res.status, res.sl, res.sid, res.fl, res.fid};
  assign out_tuser = res.hit;
  assign out_tlast = res.last;

endmodule

### rtl/lbcc_front.sv
// Front end: accepts input words, decodes the op and queues commands.
// Depends on lbcc_pkg.
module lbcc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_op,
  input  lbcc_pkg::slot_t     in_box,
  output logic                q_valid,
  output lbcc_pkg::cmd_t      q_cmd,
  input  logic                q_pop
);
  import lbcc_pkg::*;

  cmd_t       q_mem_r [QDEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  cmd_t       dec;

  always_comb begin
    case (in_op)
      OP_ADD:    dec.op = OP_ADD;
      OP_REMOVE: dec.op = OP_REMOVE;
      OP_TICK:   dec.op = OP_TICK;
      default:   dec.op = OP_NOP;
    endcase
    dec.box = in_box;
  end

  assign in_ready = (cnt_r != 2'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_cmd    = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= dec;
  end

endmodule

### rtl/lbcc_back.sv
// Back end: box table memory, add/remove sequencer, pair sweep and result register.
// Depends on lbcc_pkg.
module lbcc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  input  lbcc_pkg::cmd_t                cmd,
  output logic                          cmd_pop,
  input  logic [lbcc_pkg::CFG_W-1:0]    pair_en,
  output logic                          res_valid,
  input  logic                          res_ready,
  output lbcc_pkg::res_t                res
);
  import lbcc_pkg::*;

  slot_t              mem [TABLE_SLOTS];
  slot_t              rd_a_r, rd_b_r;
  bstate_t            state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [LYR_W-1:0]   li_r, li_nxt, lj_r, lj_nxt;
  res_t               pend_r, pend_nxt;
  logic               pend_valid_r, pend_valid_nxt;
  res_t               out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            rstat_r, rstat_nxt;
  slot_t              key_r, key_nxt;
  logic               we;
  logic [SLOT_W-1:0]  waddr;
  slot_t              wdata;

  logic can_emit, a_more, b_more, pair_last, p_on, hit_now, cmp_stall, tk_done, match;

  assign can_emit  = !out_valid_r || res_ready;
  assign a_more    = ({1'b0, a_r} + CNT_W'(1)) < cnt_r;
  assign b_more    = ({1'b0, b_r} + CNT_W'(1)) < cnt_r;
  assign pair_last = (lj_r == LYR_W'(NUM_LAYERS - 1)) && (li_r == LYR_W'(NUM_LAYERS - 2));
  assign p_on      = pair_on(li_r, lj_r, pair_en);
  assign hit_now   = p_on && (rd_a_r.layer == li_r) && (rd_b_r.layer == lj_r) &&
                     overlap(rd_a_r, rd_b_r);
  assign cmp_stall = hit_now && pend_valid_r && !can_emit;
  assign tk_done   = !a_more && !b_more && pair_last;
  assign match     = (rd_a_r.layer == key_r.layer) && (rd_a_r.id == key_r.id);

  assign cmd_pop   = (state_r == B_IDLE) && cmd_valid;
  assign res_valid = out_valid_r;
  assign res       = out_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_REMOVE: state_nxt = (cnt_r == '0) ? B_RESP : B_RS_RD;
            OP_TICK:   state_nxt = (cnt_r == '0) ? B_EMIT : B_TK_RD;
            default:   state_nxt = B_RESP;
          endcase
        end
      end
      B_RS_RD:  state_nxt = B_RS_CHK;
      B_RS_CHK: begin
        if (match) state_nxt = a_more ? B_SH_RD : B_RESP;
        else       state_nxt = a_more ? B_RS_RD : B_RESP;
      end
      B_SH_RD:  state_nxt = B_SH_WR;
      B_SH_WR:  state_nxt = a_more ? B_SH_RD : B_RESP;
      B_TK_RD: begin
        if (p_on)           state_nxt = B_TK_CMP;
        else if (pair_last) state_nxt = B_EMIT;
      end
      B_TK_CMP: begin
        if (!cmp_stall) state_nxt = tk_done ? B_EMIT : B_TK_RD;
      end
      B_EMIT, B_RESP: begin
        if (can_emit) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt        = cnt_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    li_nxt         = li_r;
    lj_nxt         = lj_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    rstat_nxt      = rstat_r;
    key_nxt        = key_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !res_ready;
    we             = 1'b0;
    waddr          = b_r;
    wdata          = rd_a_r;
    case (state_r)
      B_IDLE: begin
        if (cmd_valid) begin
          key_nxt   = cmd.box;
          a_nxt     = '0;
          b_nxt     = '0;
          li_nxt    = LYR_W'(0);
          lj_nxt    = LYR_W'(1);
          rstat_nxt = ST_OK;
          case (cmd.op)
            OP_ADD: begin
              if (cnt_r == CNT_W'(TABLE_SLOTS)) begin
                rstat_nxt = ST_FULL;
              end else begin
                we      = 1'b1;
                waddr   = cnt_r[SLOT_W-1:0];
                wdata   = cmd.box;
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            OP_REMOVE: rstat_nxt = ST_MISS;
            default: ;
          endcase
        end
      end
      B_RS_CHK: begin
        if (match) begin
          b_nxt = a_r;
          a_nxt = a_r + SLOT_W'(1);
          if (!a_more) begin
            cnt_nxt   = cnt_r - CNT_W'(1);
            rstat_nxt = ST_OK;
          end
        end else if (a_more) begin
          a_nxt = a_r + SLOT_W'(1);
        end
      end
      B_SH_WR: begin
        we    = 1'b1;
        waddr = b_r;
        wdata = rd_a_r;
        b_nxt = a_r;
        a_nxt = a_r + SLOT_W'(1);
        if (!a_more) begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          rstat_nxt = ST_OK;
        end
      end
      B_TK_RD: begin
        if (!p_on) begin
          a_nxt = '0;
          b_nxt = '0;
          if (lj_r == LYR_W'(NUM_LAYERS - 1)) begin
            li_nxt = li_r + LYR_W'(1);
            lj_nxt = li_r + LYR_W'(2);
          end else begin
            lj_nxt = lj_r + LYR_W'(1);
          end
        end
      end
      B_TK_CMP: begin
        if (!cmp_stall) begin
          if (hit_now) begin
            if (pend_valid_r) begin
              out_nxt       = pend_r;
              out_valid_nxt = 1'b1;
            end
            pend_nxt.hit    = 1'b1;
            pend_nxt.fid    = rd_a_r.id;
            pend_nxt.fl     = li_r;
            pend_nxt.sid    = rd_b_r.id;
            pend_nxt.sl     = lj_r;
            pend_nxt.status = ST_OK;
            pend_nxt.last   = 1'b0;
            pend_valid_nxt  = 1'b1;
          end
          if (b_more) begin
            b_nxt = b_r + SLOT_W'(1);
          end else begin
            b_nxt = '0;
            if (a_more) begin
              a_nxt = a_r + SLOT_W'(1);
            end else begin
              a_nxt = '0;
              if (lj_r == LYR_W'(NUM_LAYERS - 1)) begin
                li_nxt = li_r + LYR_W'(1);
                lj_nxt = li_r + LYR_W'(2);
              end else begin
                lj_nxt = lj_r + LYR_W'(1);
              end
            end
          end
        end
      end
      B_EMIT: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          if (pend_valid_r) begin
            out_nxt      = pend_r;
            out_nxt.last = 1'b1;
          end else begin
            out_nxt        = '0;
            out_nxt.status = ST_OK;
            out_nxt.last   = 1'b1;
          end
          pend_valid_nxt = 1'b0;
        end
      end
      B_RESP: begin
        if (can_emit) begin
          out_valid_nxt  = 1'b1;
          out_nxt        = '0;
          out_nxt.status = rstat_r;
          out_nxt.last   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    li_r    <= li_nxt;
    lj_r    <= lj_nxt;
    pend_r  <= pend_nxt;
    out_r   <= out_nxt;
    rstat_r <= rstat_nxt;
    key_r   <= key_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_a_r <= mem[a_r];
    rd_b_r <= mem[b_r];
  end

endmodule

### rtl/lbcc_checker.sv
// Port-level checks for the layered box collision check, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module lbcc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [0:0]  out_tuser,
  input logic        out_tlast
);

  `CHK_ALWAYS(a_rst_quiet, clk, !rst_n, !out_tvalid)
  `CHK_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `CHK_NOW(a_hit_ok, clk, rst_n, out_tvalid && out_tuser[0], out_tdata[21:20] == 2'd0)
  `CHK_NOW(a_marker_last, clk, rst_n, out_tvalid && !out_tuser[0], out_tlast && out_tdata[19:0] == 20'd0)

endmodule

bind layered_box_collision_check lbcc_checker u_lbcc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
